// ===== rtl/asc_pq_pkg.sv =====
// Shared types and codes for the ascending sorted priority queue.
`timescale 1ns / 1ps

package asc_pq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int VALUE_W = 32;
   localparam int KIND_W = 2;
   localparam int COUNT_FIELD_W = 5;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

// ===== rtl/asc_pq_cell.sv =====
// One storage cell of the sorted chain: holds an entry, shifts left or right.
`timescale 1ns / 1ps

module asc_pq_cell #(
   parameter int COUNT_W = 5,
   parameter int INDEX   = 0
) (
   input  logic                                 clock,
   input  asc_pq_pkg::cell_cmd_type             cmd,
   input  logic [COUNT_W-1:0]                   count,
   input  logic                                 left_ge,
   input  logic signed [asc_pq_pkg::VALUE_W-1:0] left_entry,
   input  logic signed [asc_pq_pkg::VALUE_W-1:0] right_entry,
   output logic                                 ge,
   output logic signed [asc_pq_pkg::VALUE_W-1:0] entry,
   output logic signed [asc_pq_pkg::VALUE_W-1:0] entry_next
);

   localparam logic [COUNT_W-1:0] IDX = COUNT_W'(INDEX);

   logic signed [asc_pq_pkg::VALUE_W-1:0] entry_ff;
   logic signed [asc_pq_pkg::VALUE_W-1:0] entry_in;
   logic                                  occupied;

   assign occupied = count > IDX;
   // this cell is at or past the insert point
   assign ge = !occupied || (entry_ff > cmd.value);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         asc_pq_pkg::OP_INSERT: begin
            if (left_ge) begin
               entry_in = left_entry;
            end else if (ge) begin
               entry_in = cmd.value;
            end
         end
         asc_pq_pkg::OP_REMOVE: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

// ===== rtl/ascending_sorted_priority_queue_top.sv =====
// Top level of the ascending sorted priority queue: cell chain, count and result register.
`timescale 1ns / 1ps

// Accepts one item (insert, remove smallest, clear) per clock cycle. Every
// cell of the chain compares its entry with the broadcast insert value in the
// same cycle and shifts toward its neighbor, so an operation completes in the
// cycle it is accepted; its result appears in the output register on the next
// cycle. The only limit on rate is the result register: req_ready drops only
// while a result waits and rsp_ready is low. Equal values leave in arrival
// order. No clearing pass is needed after reset.
module ascending_sorted_priority_queue_top #(
   parameter int QUEUE_DEPTH = asc_pq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [asc_pq_pkg::KIND_W-1:0]               req_kind,
   input  logic signed [asc_pq_pkg::VALUE_W-1:0]       req_value,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [asc_pq_pkg::VALUE_W-1:0]       rsp_front_value,
   output logic [asc_pq_pkg::COUNT_FIELD_W-1:0]        rsp_entry_count,
   output logic                                        rsp_is_empty,
   output logic [asc_pq_pkg::STATUS_W-1:0]             rsp_status
);

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(QUEUE_DEPTH);

   logic [COUNT_W-1:0] count_ff, count_in, count_nxt;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [asc_pq_pkg::VALUE_W-1:0]      front_ff, front_in;
   logic [asc_pq_pkg::COUNT_FIELD_W-1:0]       rcount_ff, rcount_in;
   logic                                       empty_ff, empty_in;
   logic [asc_pq_pkg::STATUS_W-1:0]            status_ff, status_in, status_nxt;

   logic                     accept;
   asc_pq_pkg::cell_op_type  op;
   asc_pq_pkg::cell_cmd_type cmd;

   logic                                  ge   [QUEUE_DEPTH];
   logic signed [asc_pq_pkg::VALUE_W-1:0] ent  [QUEUE_DEPTH];
   logic signed [asc_pq_pkg::VALUE_W-1:0] entn [QUEUE_DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      op         = asc_pq_pkg::OP_HOLD;
      count_nxt  = count_ff;
      status_nxt = asc_pq_pkg::STATUS_OK;
      case (req_kind)
         asc_pq_pkg::KIND_INSERT: begin
            if (count_ff == DEPTH_C) begin
               status_nxt = asc_pq_pkg::STATUS_FULL;
            end else begin
               op        = asc_pq_pkg::OP_INSERT;
               count_nxt = count_ff + COUNT_W'(1);
            end
         end
         asc_pq_pkg::KIND_REMOVE: begin
            if (count_ff == '0) begin
               status_nxt = asc_pq_pkg::STATUS_EMPTY;
            end else begin
               op        = asc_pq_pkg::OP_REMOVE;
               count_nxt = count_ff - COUNT_W'(1);
            end
         end
         asc_pq_pkg::KIND_CLEAR: begin
            count_nxt = '0;
         end
         default: begin
            op = asc_pq_pkg::OP_HOLD;
         end
      endcase
   end

   assign cmd.op    = accept ? op : asc_pq_pkg::OP_HOLD;
   assign cmd.value = req_value;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                                  l_ge;
      logic signed [asc_pq_pkg::VALUE_W-1:0] l_ent;
      logic signed [asc_pq_pkg::VALUE_W-1:0] r_ent;
      if (i == 0) begin : g_first
         assign l_ge  = 1'b0;
         assign l_ent = '0;
      end else begin : g_mid
         assign l_ge  = ge[i-1];
         assign l_ent = ent[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign r_ent = ent[i];
      end else begin : g_inner
         assign r_ent = ent[i+1];
      end
      asc_pq_cell #(
         .COUNT_W (COUNT_W),
         .INDEX   (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .left_ge     (l_ge),
         .left_entry  (l_ent),
         .right_entry (r_ent),
         .ge          (ge[i]),
         .entry       (ent[i]),
         .entry_next  (entn[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      front_in     = front_ff;
      rcount_in    = rcount_ff;
      empty_in     = empty_ff;
      status_in    = status_ff;
      if (accept) begin
         count_in     = count_nxt;
         rsp_valid_in = 1'b1;
         front_in     = (count_nxt == '0) ? '0 : entn[0];
         rcount_in    = asc_pq_pkg::COUNT_FIELD_W'(count_nxt);
         empty_in     = (count_nxt == '0);
         status_in    = status_nxt;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff  <= front_in;
      rcount_ff <= rcount_in;
      empty_ff  <= empty_in;
      status_ff <= status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = front_ff;
   assign rsp_entry_count = rcount_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_status      = status_ff;

endmodule

// ===== test/ascending_sorted_priority_queue_top_tb.sv =====
// Self-checking testbench for the ascending sorted priority queue top level.
`timescale 1ns / 1ps

module ascending_sorted_priority_queue_top_tb;

   localparam int DEPTH = asc_pq_pkg::DEFAULT_QUEUE_DEPTH;
   localparam logic [asc_pq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef logic [asc_pq_pkg::VALUE_W-1:0] word_type;

   typedef struct {
      logic [asc_pq_pkg::KIND_W-1:0]         kind;
      logic signed [asc_pq_pkg::VALUE_W-1:0] value;
   } queue_op_type;

   typedef struct {
      logic signed [asc_pq_pkg::VALUE_W-1:0] front_value;
      logic [asc_pq_pkg::COUNT_FIELD_W-1:0]  entry_count;
      logic                                  is_empty;
      logic [asc_pq_pkg::STATUS_W-1:0]       status;
   } queue_snapshot_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic [asc_pq_pkg::KIND_W-1:0]         req_kind = asc_pq_pkg::KIND_CLEAR;
   logic signed [asc_pq_pkg::VALUE_W-1:0] req_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic signed [asc_pq_pkg::VALUE_W-1:0] rsp_front_value;
   logic [asc_pq_pkg::COUNT_FIELD_W-1:0]  rsp_entry_count;
   logic                                  rsp_is_empty;
   logic [asc_pq_pkg::STATUS_W-1:0]       rsp_status;

   queue_op_type       op_backlog[$];
   queue_snapshot_type expected_snapshots[$];
   logic signed [asc_pq_pkg::VALUE_W-1:0] held_values[DEPTH];
   int unsigned     held_count = 0;
   int unsigned     error_count = 0;
   int unsigned     sender_idle_pct = 0;
   int unsigned     rsp_stall_pct = 0;
   logic            rsp_hold = 1'b0;
   logic            req_fired = 1'b0;
   logic            drained = 1'b0;

   ascending_sorted_priority_queue_top #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_front_value (rsp_front_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(string what, word_type got, word_type want);
      $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Sorted insert after all entries <= value; equal values keep arrival order.
   function automatic queue_snapshot_type apply_queue_op(
         logic [asc_pq_pkg::KIND_W-1:0] kind,
         logic signed [asc_pq_pkg::VALUE_W-1:0] value);
      queue_snapshot_type snap;
      int unsigned        slot;
      int unsigned        i;
      snap.status = asc_pq_pkg::STATUS_OK;
      case (kind)
         asc_pq_pkg::KIND_INSERT: begin
            if (held_count >= DEPTH) begin
               snap.status = asc_pq_pkg::STATUS_FULL;
            end else begin
               slot = 0;
               while (slot < held_count && held_values[slot] <= value)
                  slot++;
               for (i = held_count; i > slot; i--)
                  held_values[i] = held_values[i-1];
               held_values[slot] = value;
               held_count++;
            end
         end
         asc_pq_pkg::KIND_REMOVE: begin
            if (held_count == 0) begin
               snap.status = asc_pq_pkg::STATUS_EMPTY;
            end else begin
               for (i = 1; i < held_count; i++)
                  held_values[i-1] = held_values[i];
               held_count--;
            end
         end
         asc_pq_pkg::KIND_CLEAR: held_count = 0;
         default: ;
      endcase
      snap.front_value = (held_count > 0) ? held_values[0] : '0;
      snap.entry_count = held_count[asc_pq_pkg::COUNT_FIELD_W-1:0];
      snap.is_empty    = (held_count == 0);
      return snap;
   endfunction

   function automatic queue_op_type random_op(int unsigned insert_pct);
      queue_op_type op;
      int unsigned  roll;
      roll = $urandom_range(99);
      op.value = $urandom;
      case ($urandom_range(3))
         0: op.value = $urandom_range(15) - 8;
         1: op.value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: ;
      endcase
      if (roll < 2)
         op.kind = KIND_UNUSED;
      else if (roll < 5)
         op.kind = asc_pq_pkg::KIND_CLEAR;
      else if (roll < insert_pct)
         op.kind = asc_pq_pkg::KIND_INSERT;
      else
         op.kind = asc_pq_pkg::KIND_REMOVE;
      return op;
   endfunction

   task automatic push_op(logic [asc_pq_pkg::KIND_W-1:0] kind, word_type value);
      queue_op_type op;
      op.kind  = kind;
      op.value = value;
      op_backlog.push_back(op);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      do @(negedge clock); while (!drained);
      @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      queue_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (op_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            op = op_backlog.pop_front();
            req_valid <= 1'b1;
            req_kind  <= op.kind;
            req_value <= op.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // monitor: check results first, then predict the item taken this edge
   always @(posedge clock) begin : monitor_proc
      queue_snapshot_type want;
      req_fired <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_snapshots.size() == 0) begin
               report_mismatch("unexpected item", rsp_front_value, '0);
            end else begin
               want = expected_snapshots.pop_front();
               if (rsp_front_value !== want.front_value)
                  report_mismatch("front_value", rsp_front_value, want.front_value);
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", word_type'(rsp_entry_count),
                                  word_type'(want.entry_count));
               if (rsp_is_empty !== want.is_empty)
                  report_mismatch("is_empty", word_type'(rsp_is_empty),
                                  word_type'(want.is_empty));
               if (rsp_status !== want.status)
                  report_mismatch("status", word_type'(rsp_status),
                                  word_type'(want.status));
            end
         end
         if (req_valid && req_ready)
            expected_snapshots.push_back(apply_queue_op(req_kind, req_value));
      end
      drained <= !reset && op_backlog.size() == 0 && !req_valid
                 && expected_snapshots.size() == 0;
   end

   initial begin
      #200_000;
      $display("ascending_sorted_priority_queue_top_tb: errors");
      $finish;
   end

   initial begin
      int unsigned phase;
      int unsigned burst;
      int unsigned n;
      int unsigned insert_pct;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-queue cases, extremes, fill to full, overflow, drain
      push_op(asc_pq_pkg::KIND_REMOVE, 32'h0000_0000);
      push_op(asc_pq_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
      push_op(KIND_UNUSED, 32'h1234_5678);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h7FFF_FFFF);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h8000_0000);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h0000_0000);
      push_op(asc_pq_pkg::KIND_INSERT, 32'hFFFF_FFFF);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h0000_0001);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h0000_0005);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h0000_0005);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h0000_0005);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h8000_0000);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h7FFF_FFFF);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h5555_5555);
      push_op(asc_pq_pkg::KIND_INSERT, 32'hAAAA_AAAA);
      push_op(asc_pq_pkg::KIND_INSERT, 32'hFFFF_FFFE);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h0000_0002);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h7FFF_FFFE);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h8000_0001);
      push_op(asc_pq_pkg::KIND_INSERT, 32'h0000_0007);
      push_op(KIND_UNUSED, 32'h0000_0000);
      push_op(asc_pq_pkg::KIND_REMOVE, 32'hFFFF_FFFF);
      push_op(asc_pq_pkg::KIND_REMOVE, 32'h0000_0000);
      push_op(asc_pq_pkg::KIND_CLEAR, 32'h0000_0000);
      push_op(asc_pq_pkg::KIND_REMOVE, 32'h0000_0000);
      wait_drained();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 71; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 71; end
            default: begin sender_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         for (burst = 0; burst < 7; burst++) begin
            case ($urandom_range(2))
               0: insert_pct = 85;
               1: insert_pct = 55;
               default: insert_pct = 20;
            endcase
            for (n = 0; n < 24; n++)
               op_backlog.push_back(random_op(insert_pct));
         end
         wait_drained();
      end

      // back-pressure: receiver holds off while items keep coming
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold = 1'b1;
      for (n = 0; n < 60; n++)
         op_backlog.push_back(random_op(70));
      repeat (200) @(posedge clock);
      rsp_hold = 1'b0;
      wait_drained();

      repeat (20) @(posedge clock);
      if (expected_snapshots.size() != 0)
         report_mismatch("items never returned", word_type'(expected_snapshots.size()),
                         '0);
      if (error_count == 0)
         $display("ascending_sorted_priority_queue_top_tb: clean");
      else
         $display("ascending_sorted_priority_queue_top_tb: errors");
      $finish;
   end

endmodule
